/* rtl/cimf_pkg.sv */
// Shared constants, codes and types for the CAN identifier mask filter table.
package cimf_pkg;

    localparam int FILTER_ENTRIES = 16;
    localparam int IDX_W          = $clog2(FILTER_ENTRIES + 1);
    localparam int ID_W           = 29;
    localparam int HND_W          = 8;
    localparam int CTX_W          = 16;
    localparam int KIND_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int OUT_IDX_W      = 5;

    localparam logic [IDX_W-1:0] IDX_NONE    = IDX_W'(FILTER_ENTRIES);
    localparam logic [ID_W-1:0]  STD_ID_MAX  = ID_W'(29'h7FF);
    localparam logic [ID_W-1:0]  ID_ALL_ONES = {ID_W{1'b1}};

    localparam logic [KIND_W-1:0] KIND_REG_STD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REG_EXT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RX      = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // Search word that walks down the row of filter cells.
    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  frame_id;
        logic             match_found;
        logic [IDX_W-1:0] match_idx;
        logic             empty_found;
        logic [IDX_W-1:0] empty_idx;
        logic             hset;
        logic             is_ext;
        logic [HND_W-1:0] handler;
        logic [CTX_W-1:0] context_tag;
    } t_scan;

    // Write broadcast to all cells; only the addressed cell takes it.
    typedef struct packed {
        logic             en;
        logic             fill;
        logic [IDX_W-1:0] idx;
        logic [HND_W-1:0] handler;
        logic [ID_W-1:0]  ident;
        logic [ID_W-1:0]  mask;
        logic             is_ext;
        logic [CTX_W-1:0] context_tag;
    } t_wr;

endpackage

/* rtl/cimf_cell.sv */
// One filter entry that checks the passing search word and forwards it.
module cimf_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [cimf_pkg::IDX_W-1:0] i_cell_idx,
    input  cimf_pkg::t_scan          i_pkt,
    input  cimf_pkg::t_wr            i_wr,
    output cimf_pkg::t_scan          o_pkt
);
    import cimf_pkg::*;

    logic [ID_W-1:0]  r_ident;
    logic [ID_W-1:0]  r_mask;
    logic             r_is_ext;
    logic [HND_W-1:0] r_handler;
    logic             r_hset;
    logic [CTX_W-1:0] r_context;
    t_scan            r_pkt;
    t_scan            n_pkt;
    logic             w_hit;
    logic             w_empty;

    assign w_hit   = ((r_ident ^ i_pkt.frame_id) & r_mask) == '0;
    assign w_empty = r_ident == '0;

    always_comb begin
        n_pkt = i_pkt;
        if (i_pkt.valid && !i_pkt.match_found && w_hit) begin
            n_pkt.match_found = 1'b1;
            n_pkt.match_idx   = i_cell_idx;
            n_pkt.hset        = r_hset;
            n_pkt.is_ext      = r_is_ext;
            n_pkt.handler     = r_handler;
            n_pkt.context_tag = r_context;
        end
        if (i_pkt.valid && !i_pkt.empty_found && w_empty) begin
            n_pkt.empty_found = 1'b1;
            n_pkt.empty_idx   = i_cell_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt <= '0;
        end else begin
            r_pkt <= n_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ident   <= '0;
            r_mask    <= ID_ALL_ONES;
            r_is_ext  <= 1'b0;
            r_handler <= '0;
            r_hset    <= 1'b0;
            r_context <= '0;
        end else if (i_wr.en && i_wr.idx == i_cell_idx) begin
            r_handler <= i_wr.handler;
            r_hset    <= 1'b1;
            if (i_wr.fill) begin
                r_ident   <= i_wr.ident;
                r_mask    <= i_wr.mask;
                r_is_ext  <= i_wr.is_ext;
                r_context <= i_wr.context_tag;
            end
        end
    end

    assign o_pkt = r_pkt;

endmodule

/* rtl/can_id_mask_filter_table_top.sv */
// An accepted word is registered at the head of the row of filter cells, walks the row
// through one register per cell, is captured into the pending register and commits to
// the output registers once the output is free. The result waits in the pending register
// while the output stalls; the next word is taken only after it commits.
// Reset (synchronous, active low) clears all identifiers, sets all masks to all ones
// and clears every handler-set mark; it needs no sweep and the block is ready at once.
module can_id_mask_filter_table_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [cimf_pkg::KIND_W-1:0]     i_kind,
    input  logic [cimf_pkg::ID_W-1:0]       i_frame_id,
    input  logic [cimf_pkg::ID_W-1:0]       i_id_mask,
    input  logic                            i_extended_flag,
    input  logic [cimf_pkg::HND_W-1:0]      i_handler_tag,
    input  logic [cimf_pkg::CTX_W-1:0]      i_context_tag,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [cimf_pkg::STATUS_W-1:0]   o_status,
    output logic                            o_dispatch,
    output logic [cimf_pkg::OUT_IDX_W-1:0]  o_entry_index,
    output logic [cimf_pkg::HND_W-1:0]      o_out_handler,
    output logic [cimf_pkg::CTX_W-1:0]      o_out_context
);
    import cimf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state            r_state;
    t_state            n_state;
    t_scan             r_head;
    t_scan             n_head;
    t_scan             r_pend;
    t_scan             n_pend;
    logic [KIND_W-1:0] r_kind;
    logic [ID_W-1:0]   r_mask_in;
    logic              r_ext;
    logic [HND_W-1:0]  r_hnd;
    logic [CTX_W-1:0]  r_ctx;

    logic                r_out_valid;
    logic                n_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;
    logic                r_dispatch;
    logic                n_dispatch;
    logic [IDX_W-1:0]    r_index;
    logic [IDX_W-1:0]    n_index;
    logic [HND_W-1:0]    r_out_hnd;
    logic [HND_W-1:0]    n_out_hnd;
    logic [CTX_W-1:0]    r_out_ctx;
    logic [CTX_W-1:0]    n_out_ctx;

    t_scan w_link [FILTER_ENTRIES+1];
    t_wr   w_wr;
    logic  w_accept;
    logic  w_out_free;
    logic  w_commit;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_commit   = (r_state == S_HOLD) && w_out_free;

    assign w_link[0] = r_head;

    for (genvar g = 0; g < FILTER_ENTRIES; g++) begin : g_cell
        cimf_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (IDX_W'(g)),
            .i_pkt      (w_link[g]),
            .i_wr       (w_wr),
            .o_pkt      (w_link[g+1])
        );
    end

    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        n_head  = r_head;
        n_head.valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state            = S_SCAN;
                    n_head.valid       = 1'b1;
                    n_head.frame_id    = i_frame_id;
                    n_head.match_found = 1'b0;
                    n_head.match_idx   = IDX_NONE;
                    n_head.empty_found = 1'b0;
                    n_head.empty_idx   = IDX_NONE;
                    n_head.hset        = 1'b0;
                    n_head.is_ext      = 1'b0;
                    n_head.handler     = '0;
                    n_head.context_tag = '0;
                end
            end
            S_SCAN: begin
                if (w_link[FILTER_ENTRIES].valid) begin
                    n_pend  = w_link[FILTER_ENTRIES];
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_status   = ST_OK;
        n_dispatch = 1'b0;
        n_index    = IDX_NONE;
        n_out_hnd  = '0;
        n_out_ctx  = '0;
        w_wr.en          = 1'b0;
        w_wr.fill        = 1'b0;
        w_wr.idx         = IDX_NONE;
        w_wr.handler     = r_hnd;
        w_wr.ident       = r_pend.frame_id;
        w_wr.mask        = (r_kind == KIND_REG_STD) ? STD_ID_MAX : r_mask_in;
        w_wr.is_ext      = (r_kind == KIND_REG_EXT);
        w_wr.context_tag = r_ctx;
        case (r_kind)
            KIND_REG_STD, KIND_REG_EXT: begin
                if (r_kind == KIND_REG_STD && r_pend.frame_id > STD_ID_MAX) begin
                    n_status = ST_INVALID;
                end else if (r_pend.match_found) begin
                    w_wr.en  = w_commit;
                    w_wr.idx = r_pend.match_idx;
                    n_index  = r_pend.match_idx;
                end else if (r_pend.empty_found) begin
                    w_wr.en   = w_commit;
                    w_wr.fill = 1'b1;
                    w_wr.idx  = r_pend.empty_idx;
                    n_index   = r_pend.empty_idx;
                end else begin
                    n_status = ST_FULL;
                end
            end
            KIND_RX: begin
                if (r_pend.match_found) begin
                    n_index = r_pend.match_idx;
                    if (r_pend.hset && r_pend.is_ext == r_ext) begin
                        n_dispatch = 1'b1;
                        n_out_hnd  = r_pend.handler;
                        n_out_ctx  = r_pend.context_tag;
                    end
                end
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
        if (w_commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (!i_rst_n) begin
            r_head <= '0;
        end else begin
            r_head <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind    <= i_kind;
            r_mask_in <= i_id_mask;
            r_ext     <= i_extended_flag;
            r_hnd     <= i_handler_tag;
            r_ctx     <= i_context_tag;
        end
        if (w_commit) begin
            r_status   <= n_status;
            r_dispatch <= n_dispatch;
            r_index    <= n_index;
            r_out_hnd  <= n_out_hnd;
            r_out_ctx  <= n_out_ctx;
        end
    end

    assign o_in_stall    = r_state != S_IDLE;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_dispatch    = r_dispatch;
    assign o_entry_index = OUT_IDX_W'(r_index);
    assign o_out_handler = r_out_hnd;
    assign o_out_context = r_out_ctx;

endmodule
